>>> src/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg: shared types and constants of the line follower drive unit
// Sizes of the sensor row, the integral, the fixed-point products and the
// configuration register map.
// ----------------------------------------------------------------------------
package lfpd_pkg;

    // Sensor row and position
    localparam int SENSOR_COUNT  = 8;
    localparam int SENSOR_WEIGHT = 100;
    localparam int TOTAL_MAX     = SENSOR_WEIGHT * SENSOR_COUNT * (SENSOR_COUNT - 1) / 2;
    localparam int TOTAL_W       = $clog2(TOTAL_MAX + 1);
    localparam int ACT_W         = $clog2(SENSOR_COUNT + 1);
    localparam int STEP_W        = $clog2(TOTAL_W);

    // Register and field widths
    localparam int GAIN_W     = 12;
    localparam int SPEED_W    = 8;
    localparam int CENTER_W   = 10;
    localparam int POS_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int POS_MAX         = (1 << POS_W) - 1;
    localparam int LINE_POS_RAW    = SENSOR_WEIGHT * (SENSOR_COUNT - 1);
    localparam int LINE_POS_MAX    = (LINE_POS_RAW < POS_MAX) ? LINE_POS_RAW : POS_MAX;
    localparam int SPEED_MAX       = (1 << SPEED_W) - 1;

    // Error, integral and derivative
    localparam int    SUM_WIDTH = 24;
    localparam int    ERR_W     = 11;
    localparam int    DERIV_W   = ERR_W + 1;
    localparam int    ERR_MAX   = (1 << (ERR_W - 1)) - 1;
    localparam int    ERR_MIN   = -(1 << (ERR_W - 1));
    localparam longint SUM_MAX  = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
    localparam longint SUM_MIN  = -(longint'(1) <<< (SUM_WIDTH - 1));
    localparam int    DIFF_W    = ((TOTAL_W > CENTER_W) ? TOTAL_W : CENTER_W) + 1;

    // Shared multiplier and fixed-point accumulators
    localparam int PID_W        = SUM_WIDTH + GAIN_W + 2;
    localparam int LO_W         = PID_W / 2;
    localparam int HI_W         = PID_W - LO_W;
    localparam int MUL_A_W      = SUM_WIDTH + 1;
    localparam int MUL_B_W      = GAIN_W + 1;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;
    localparam int CORR_W       = PID_W + MUL_B_W;
    localparam int RAW_W        = CORR_W + 1;
    localparam int FRAC_W       = 16;
    localparam int DRV_W        = 16;
    localparam int DRV_MAX      = (1 << DRV_W) - 1;
    localparam int SCALE_FRAC_W = 8;

    // Register reset values
    localparam logic [GAIN_W-1:0]   KP_RST     = GAIN_W'(69);
    localparam logic [GAIN_W-1:0]   KI_RST     = GAIN_W'(0);
    localparam logic [GAIN_W-1:0]   KD_RST     = GAIN_W'(33);
    localparam logic [GAIN_W-1:0]   KS_RST     = GAIN_W'(410);
    localparam logic [SPEED_W-1:0]  BASE_RST   = SPEED_W'(120);
    localparam logic [SPEED_W-1:0]  SCALE_RST  = SPEED_W'(179);
    localparam logic [CENTER_W-1:0] CENTER_RST = CENTER_W'(350);

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP     = 0,
        REG_KI     = 1,
        REG_KD     = 2,
        REG_KS     = 3,
        REG_BASE   = 4,
        REG_SCALE  = 5,
        REG_CENTER = 6
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]   kp;
        logic [GAIN_W-1:0]   ki;
        logic [GAIN_W-1:0]   kd;
        logic [GAIN_W-1:0]   ks;
        logic [SPEED_W-1:0]  base_speed;
        logic [SPEED_W-1:0]  speed_scale;
        logic [CENTER_W-1:0] center;
    } t_cfg;

    // Operand selection of the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_KP,
        MUL_KI,
        MUL_KD,
        MUL_LO,
        MUL_HI,
        MUL_SL,
        MUL_SR
    } t_mul_op;

endpackage

>>> src/lfpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// lfpd_cfg_regs: configuration register file
// Holds the gains, speeds and centre position; one register per write word.
// ----------------------------------------------------------------------------
module lfpd_cfg_regs import lfpd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    // Load the addressed register, drop writes to unknown indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp          <= KP_RST;
            r_cfg.ki          <= KI_RST;
            r_cfg.kd          <= KD_RST;
            r_cfg.ks          <= KS_RST;
            r_cfg.base_speed  <= BASE_RST;
            r_cfg.speed_scale <= SCALE_RST;
            r_cfg.center      <= CENTER_RST;
        end else if (i_wr_en) begin
            case (i_index)
                REG_KP:     r_cfg.kp          <= i_data[GAIN_W-1:0];
                REG_KI:     r_cfg.ki          <= i_data[GAIN_W-1:0];
                REG_KD:     r_cfg.kd          <= i_data[GAIN_W-1:0];
                REG_KS:     r_cfg.ks          <= i_data[GAIN_W-1:0];
                REG_BASE:   r_cfg.base_speed  <= i_data[SPEED_W-1:0];
                REG_SCALE:  r_cfg.speed_scale <= i_data[SPEED_W-1:0];
                REG_CENTER: r_cfg.center      <= i_data[CENTER_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/lfpd_div.sv
// ----------------------------------------------------------------------------
// lfpd_div: restoring divider for the line position
// Divides the weighted sensor total by the active count, one quotient bit
// per cycle; pulses done for one cycle when the quotient is ready.
// ----------------------------------------------------------------------------
module lfpd_div import lfpd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [TOTAL_W-1:0] i_dividend,
    input  logic [ACT_W-1:0]   i_divisor,
    output logic               o_done,
    output logic [TOTAL_W-1:0] o_quotient
);

    logic               r_busy;
    logic               r_done;
    logic [STEP_W-1:0]  r_step;
    logic [ACT_W-1:0]   r_rem;
    logic [ACT_W-1:0]   r_dvs;
    logic [TOTAL_W-1:0] r_quo;

    logic [ACT_W:0]     w_trial;
    logic               w_fit;
    logic [ACT_W:0]     w_diff;

    // Trial subtract of the next dividend bit
    always_comb begin
        w_trial = {r_rem, r_quo[TOTAL_W-1]};
        w_fit   = (w_trial >= {1'b0, r_dvs});
        w_diff  = w_trial - {1'b0, r_dvs};
    end

    // Shift dividend out and quotient in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(TOTAL_W - 1);
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem  <= w_fit ? w_diff[ACT_W-1:0] : w_trial[ACT_W-1:0];
                r_quo  <= {r_quo[TOTAL_W-2:0], w_fit};
                r_step <= r_step - STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> src/lfpd_mul.sv
// ----------------------------------------------------------------------------
// lfpd_mul: shared signed multiplier with operand selection
// Serves the three gain products, both halves of the steering product and
// the two speed scalings, one per cycle as the sequencer selects.
// ----------------------------------------------------------------------------
module lfpd_mul import lfpd_pkg::*; (
    input  t_mul_op                    i_op,
    input  t_cfg                       i_cfg,
    input  logic signed [ERR_W-1:0]    i_err,
    input  logic signed [SUM_WIDTH-1:0] i_sum,
    input  logic signed [DERIV_W-1:0]  i_deriv,
    input  logic signed [PID_W-1:0]    i_pid,
    input  logic [DRV_W-1:0]           i_drv_l,
    input  logic [DRV_W-1:0]           i_drv_r,
    output logic signed [PROD_W-1:0]   o_prod
);

    logic signed [MUL_A_W-1:0] w_a;
    logic signed [MUL_B_W-1:0] w_b;
    logic signed [HI_W-1:0]    w_pid_hi;

    assign w_pid_hi = i_pid[PID_W-1:LO_W];

    // Pick the operand pair for this step
    always_comb begin
        case (i_op)
            MUL_KP: begin
                w_a = MUL_A_W'(i_err);
                w_b = MUL_B_W'(i_cfg.kp);
            end
            MUL_KI: begin
                w_a = MUL_A_W'(i_sum);
                w_b = MUL_B_W'(i_cfg.ki);
            end
            MUL_KD: begin
                w_a = MUL_A_W'(i_deriv);
                w_b = MUL_B_W'(i_cfg.kd);
            end
            MUL_LO: begin
                w_a = MUL_A_W'(i_pid[LO_W-1:0]);
                w_b = MUL_B_W'(i_cfg.ks);
            end
            MUL_HI: begin
                w_a = MUL_A_W'(w_pid_hi);
                w_b = MUL_B_W'(i_cfg.ks);
            end
            MUL_SL: begin
                w_a = MUL_A_W'(i_drv_l);
                w_b = MUL_B_W'(i_cfg.speed_scale);
            end
            MUL_SR: begin
                w_a = MUL_A_W'(i_drv_r);
                w_b = MUL_B_W'(i_cfg.speed_scale);
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign o_prod = w_a * w_b;

endmodule

>>> src/line_follow_pid_drive_unit.sv
// ----------------------------------------------------------------------------
// line_follow_pid_drive_unit: PID steering for a two-motor line follower
// Turns one sample of the line sensors into left and right drive values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one sensor word. Output
//   channel: o_out_valid / i_out_stall carry left_speed, right_speed,
//   line_lost and line_position. Configuration: i_cfg_valid / o_cfg_ready
//   with i_cfg_index and i_cfg_data write one register; ready is always high.
//   Write registers only while no word is in flight.
//   When the line is seen, the restoring divider finds the position one bit
//   per cycle over 12 bits and then pulses done, and the sequencer then takes
//   11 steps around the one shared multiplier before the result is loaded
//   into the output register. A word with no active sensor skips the divider
//   and the multiplier steps and goes straight to the output step.
//   o_in_stall is high from acceptance until the result is loaded into the
//   output register, so a new word is taken only once the last one is out.
//   A result waits in the output register while i_out_stall is high; the
//   sequencer holds the next result in its last step until that slot frees.
//   Reset clears the integral and the previous error, loads the register
//   defaults and empties the output register.
// ----------------------------------------------------------------------------
module line_follow_pid_drive_unit import lfpd_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [SENSOR_COUNT-1:0] i_line_sensors,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [SPEED_W-1:0]      o_left_speed,
    output logic [SPEED_W-1:0]      o_right_speed,
    output logic                    o_line_lost,
    output logic [POS_W-1:0]        o_line_position,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_ERR, S_MKP, S_MKI, S_MKD, S_MCL, S_MCH,
        S_SPL, S_SPR, S_MSL, S_MSR, S_OUT
    } t_state;

    t_state r_state;
    t_cfg   w_cfg;

    logic                     r_out_valid;
    logic [SPEED_W-1:0]       r_o_left;
    logic [SPEED_W-1:0]       r_o_right;
    logic                     r_o_lost;
    logic [POS_W-1:0]         r_o_pos;

    logic                     r_lost;
    logic [TOTAL_W-1:0]       r_pos;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [ERR_W-1:0]  r_prior;
    logic signed [DERIV_W-1:0] r_deriv;
    logic signed [SUM_WIDTH-1:0] r_sum;
    logic signed [PID_W-1:0]  r_acc;
    logic signed [CORR_W-1:0] r_corr;
    logic [DRV_W-1:0]         r_wl;
    logic [DRV_W-1:0]         r_wr;
    logic [SPEED_W-1:0]       r_spl;
    logic [SPEED_W-1:0]       r_spr;

    logic                     w_in_accept;
    logic [TOTAL_W-1:0]       w_total;
    logic [ACT_W-1:0]         w_active;
    logic                     w_div_done;
    logic [TOTAL_W-1:0]       w_quotient;
    t_mul_op                  w_mul_op;
    logic signed [PROD_W-1:0] w_prod;

    logic signed [DIFF_W-1:0]    w_diff;
    logic signed [ERR_W-1:0]     n_err;
    logic signed [SUM_WIDTH:0]   w_sum_ext;
    logic signed [SUM_WIDTH-1:0] n_sum;
    logic signed [DERIV_W-1:0]   n_deriv;
    logic signed [RAW_W-1:0]     w_base16;
    logic signed [RAW_W-1:0]     w_raw_l;
    logic signed [RAW_W-1:0]     w_raw_r;
    logic [POS_W-1:0]            n_pos_out;

    // Clamp a Q16 wheel speed to a non-negative 16-bit drive value
    function automatic logic [DRV_W-1:0] sat_drive(input logic signed [RAW_W-1:0] v);
        logic [RAW_W-FRAC_W-1:0] whole;
        whole = v[RAW_W-1:FRAC_W];
        if (v < 0) begin
            return '0;
        end else if (whole > (RAW_W - FRAC_W)'(DRV_MAX)) begin
            return DRV_W'(DRV_MAX);
        end else begin
            return v[FRAC_W+DRV_W-1:FRAC_W];
        end
    endfunction

    // Drop the Q0.8 fraction of a scaled speed and clamp to the output range
    function automatic logic [SPEED_W-1:0] sat_speed(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-SCALE_FRAC_W-1:0] whole;
        whole = p[PROD_W-1:SCALE_FRAC_W];
        if (whole > (PROD_W - SCALE_FRAC_W)'(SPEED_MAX)) begin
            return SPEED_W'(SPEED_MAX);
        end else begin
            return whole[SPEED_W-1:0];
        end
    endfunction

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    lfpd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    // Weighted total and count of the active sensors
    always_comb begin
        w_total  = '0;
        w_active = '0;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (i_line_sensors[i]) begin
                w_total  = w_total + TOTAL_W'(SENSOR_WEIGHT * i);
                w_active = w_active + ACT_W'(1);
            end
        end
    end

    lfpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_accept && (w_active != '0)),
        .i_dividend (w_total),
        .i_divisor  (w_active),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Multiplier step for each sequencer state
    always_comb begin
        case (r_state)
            S_MKP:   w_mul_op = MUL_KP;
            S_MKI:   w_mul_op = MUL_KI;
            S_MKD:   w_mul_op = MUL_KD;
            S_MCL:   w_mul_op = MUL_LO;
            S_MCH:   w_mul_op = MUL_HI;
            S_MSL:   w_mul_op = MUL_SL;
            S_MSR:   w_mul_op = MUL_SR;
            default: w_mul_op = MUL_NONE;
        endcase
    end

    lfpd_mul u_mul (
        .i_op    (w_mul_op),
        .i_cfg   (w_cfg),
        .i_err   (r_err),
        .i_sum   (r_sum),
        .i_deriv (r_deriv),
        .i_pid   (r_acc),
        .i_drv_l (r_wl),
        .i_drv_r (r_wr),
        .o_prod  (w_prod)
    );

    // Error, saturating integral and derivative
    always_comb begin
        w_diff = signed'(DIFF_W'(r_pos)) - signed'(DIFF_W'(w_cfg.center));
        if (w_diff > ERR_MAX) begin
            n_err = ERR_W'(ERR_MAX);
        end else if (w_diff < ERR_MIN) begin
            n_err = ERR_W'(ERR_MIN);
        end else begin
            n_err = ERR_W'(w_diff);
        end
        w_sum_ext = (SUM_WIDTH + 1)'(r_sum) + (SUM_WIDTH + 1)'(n_err);
        if (w_sum_ext > SUM_MAX) begin
            n_sum = SUM_WIDTH'(SUM_MAX);
        end else if (w_sum_ext < SUM_MIN) begin
            n_sum = SUM_WIDTH'(SUM_MIN);
        end else begin
            n_sum = SUM_WIDTH'(w_sum_ext);
        end
        n_deriv = DERIV_W'(n_err) - DERIV_W'(r_prior);
    end

    // Wheel speeds in Q16 around the base speed
    always_comb begin
        w_base16 = signed'(RAW_W'({w_cfg.base_speed, {FRAC_W{1'b0}}}));
        w_raw_l  = w_base16 - RAW_W'(r_corr);
        w_raw_r  = w_base16 + RAW_W'(r_corr);
    end

    // Saturate the reported position to its field
    always_comb begin
        if (int'(r_pos) > POS_MAX) begin
            n_pos_out = POS_W'(POS_MAX);
        end else begin
            n_pos_out = POS_W'(r_pos);
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_prior     <= '0;
        end else begin
            // Free the output slot once its word is taken; S_OUT refills it itself
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_accept) begin
                        if (w_active == '0) begin
                            r_lost  <= 1'b1;
                            r_sum   <= '0;
                            r_pos   <= '0;
                            r_spl   <= '0;
                            r_spr   <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_lost  <= 1'b0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_pos   <= w_quotient;
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err   <= n_err;
                    r_sum   <= n_sum;
                    r_deriv <= n_deriv;
                    r_prior <= n_err;
                    r_state <= S_MKP;
                end
                S_MKP: begin
                    r_acc   <= PID_W'(w_prod);
                    r_state <= S_MKI;
                end
                S_MKI: begin
                    r_acc   <= r_acc + PID_W'(w_prod);
                    r_state <= S_MKD;
                end
                S_MKD: begin
                    r_acc   <= r_acc + PID_W'(w_prod);
                    r_state <= S_MCL;
                end
                S_MCL: begin
                    r_corr  <= CORR_W'(w_prod);
                    r_state <= S_MCH;
                end
                S_MCH: begin
                    r_corr  <= r_corr + (CORR_W'(w_prod) <<< LO_W);
                    r_state <= S_SPL;
                end
                S_SPL: begin
                    r_wl    <= sat_drive(w_raw_l);
                    r_state <= S_SPR;
                end
                S_SPR: begin
                    r_wr    <= sat_drive(w_raw_r);
                    r_state <= S_MSL;
                end
                S_MSL: begin
                    r_spl   <= sat_speed(w_prod);
                    r_state <= S_MSR;
                end
                S_MSR: begin
                    r_spr   <= sat_speed(w_prod);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the output slot is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_o_left    <= r_spl;
                        r_o_right   <= r_spr;
                        r_o_lost    <= r_lost;
                        r_o_pos     <= n_pos_out;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_left_speed    = r_o_left;
    assign o_right_speed   = r_o_right;
    assign o_line_lost     = r_o_lost;
    assign o_line_position = r_o_pos;

endmodule

>>> src/lfpd_checker.sv
// ----------------------------------------------------------------------------
// lfpd_checker: port-level checks of the line follower drive unit
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module lfpd_checker import lfpd_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic [SPEED_W-1:0]      o_left_speed,
    input logic [SPEED_W-1:0]      o_right_speed,
    input logic                    o_line_lost,
    input logic [POS_W-1:0]        o_line_position
);

    // A stalled result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_left_speed)
            && $stable(o_right_speed) && $stable(o_line_lost)
            && $stable(o_line_position))
        else $error("result word changed while stalled");

    // The unit is busy right after taking a sensor word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after accept");

    // A lost line drives both motors to zero and reports no position
    a_lost_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_lost |-> o_left_speed == '0 && o_right_speed == '0
            && o_line_position == '0)
        else $error("line lost with non-zero outputs");

    // Position stays within the span of the sensor row
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_line_lost |-> o_line_position <= POS_W'(LINE_POS_MAX))
        else $error("line position beyond sensor span");

endmodule

bind line_follow_pid_drive_unit lfpd_checker u_lfpd_checker (.*);
